// ===== hdl/cpm_pkg.sv =====
// Shared types and constants for the circular pattern matcher.
// No dependencies; imported by every module under hdl/.
package cpm_pkg;

    localparam int CHAR_W              = 8;
    localparam int PAT_BITS            = 64;
    localparam int LEN_W               = 4;
    localparam int CFG_IDX_W           = 2;
    localparam int DEFAULT_MAX_PATTERN = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              text_last;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic found_last;
    } out_item_t;

    // window update controls from the stage logic
    typedef struct packed {
        logic load;         // a text character transfer this edge
        logic retire_last;  // the item leaving the stage closes its text
    } win_ctrl_t;

endpackage

// ===== hdl/circular_pattern_matcher.sv =====
// Top level of the circular pattern matcher: config registers, stage and
// result registers. Depends on cpm_pkg, cpm_window, cpm_rot_cmp.
//
//  port group     dir  handshake          payload
//  s_*            in   s_valid / s_ready  in_item_t  (text_char, text_last)
//  m_*            out  m_valid / m_ready  out_item_t (found, found_last)
//  cfg_*          in   cfg_we             cfg_index, cfg_wdata
//
// One character per cycle unless stalled; each goes through the stage to m_valid.
// Stage 1 holds the shifted window, the rotation compare feeds the result register.
// m_ready low stalls the stage once the result register is full; s_ready then drops.
// Reset (aresetn low, synchronous) clears window, count, sticky flag and config.
module circular_pattern_matcher #(
    parameter int MAX_PATTERN = cpm_pkg::DEFAULT_MAX_PATTERN
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [cpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpm_pkg::PAT_BITS-1:0]     cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  cpm_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output cpm_pkg::out_item_t               m_data
);
    import cpm_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic [PAT_BITS-1:0] pat_chars_reg;
    logic [LEN_W-1:0]    pat_len_reg;

    logic      st_valid_reg, st_valid_next;
    logic      st_last_reg;
    logic      match_seen_reg, match_seen_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;

    logic      accept, out_take, advance, hit;
    win_ctrl_t win_ctrl;

    logic [MAX_PATTERN-1:0][CHAR_W-1:0] window;
    logic [CNT_W-1:0]                   count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_chars_reg <= '0;
            pat_len_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PATTERN_CHARS:  pat_chars_reg <= cfg_wdata;
                REG_PATTERN_LENGTH: pat_len_reg   <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_take = !m_valid_reg || m_ready;
    assign advance  = st_valid_reg && out_take;
    assign s_ready  = !st_valid_reg || out_take;
    assign accept   = s_valid && s_ready;

    assign win_ctrl.load        = accept;
    assign win_ctrl.retire_last = advance && st_last_reg;

    cpm_window #(.MAX_PATTERN(MAX_PATTERN)) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (win_ctrl),
        .new_char (s_data.text_char),
        .window   (window),
        .count    (count)
    );

    cpm_rot_cmp #(.MAX_PATTERN(MAX_PATTERN)) u_rot_cmp (
        .window         (window),
        .count          (count),
        .pattern_chars  (pat_chars_reg),
        .pattern_length (pat_len_reg),
        .hit            (hit)
    );

    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (advance) begin
            st_valid_next = 1'b0;
        end

        match_seen_next = match_seen_reg;
        if (advance) begin
            match_seen_next = st_last_reg ? 1'b0 : (match_seen_reg || hit);
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg   <= 1'b0;
            match_seen_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_valid_reg   <= st_valid_next;
            match_seen_reg <= match_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_last_reg <= s_data.text_last;
        end
        if (advance) begin
            m_data_reg.found      <= match_seen_reg || hit;
            m_data_reg.found_last <= st_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a text that closes with nothing behind it leaves a clean window
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && st_last_reg && !accept) |=>
            (count == '0 && window == '0 && !match_seen_reg))
        else $error("state not cleared after last character");

    // the sticky flag only changes when a stage item moves to the result register
    a_sticky_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(match_seen_reg) |-> $past(advance))
        else $error("match flag set without a stage transfer");

    a_empty_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        (pat_len_reg == '0) |-> !hit)
        else $error("empty pattern reported a hit");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CNT_W'(MAX_PATTERN))
        else $error("seen count past window depth");

    // a result only appears after a stage item was handed over
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st_valid_reg))
        else $error("result without a stage item");

endmodule

// ===== hdl/cpm_window.sv =====
// Recent-character window and saturating seen count.
// Depends on cpm_pkg.
module cpm_window #(
    parameter int MAX_PATTERN = cpm_pkg::DEFAULT_MAX_PATTERN
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  cpm_pkg::win_ctrl_t                           ctrl,
    input  logic [cpm_pkg::CHAR_W-1:0]                   new_char,
    output logic [MAX_PATTERN-1:0][cpm_pkg::CHAR_W-1:0]  window,
    output logic [$clog2(MAX_PATTERN+1)-1:0]             count
);
    import cpm_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATTERN);

    logic [MAX_PATTERN-1:0][CHAR_W-1:0] window_reg, window_next, window_base;
    logic [CNT_W-1:0]                   count_reg, count_next, count_base;

    always_comb begin
        // a text that just ended starts the new character from a clean window
        window_base = ctrl.retire_last ? '0 : window_reg;
        count_base  = ctrl.retire_last ? '0 : count_reg;
        window_next = window_reg;
        count_next  = count_reg;
        if (ctrl.load) begin
            for (int i = MAX_PATTERN - 1; i > 0; i--) begin
                window_next[i] = window_base[i-1];
            end
            window_next[0] = new_char;
            count_next     = (count_base == CNT_MAX) ? CNT_MAX : count_base + CNT_W'(1);
        end else if (ctrl.retire_last) begin
            window_next = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            count_reg  <= '0;
        end else begin
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    assign window = window_reg;
    assign count  = count_reg;

endmodule

// ===== hdl/cpm_rot_cmp.sv =====
// Parallel compare of the window against every rotation of the pattern,
// one compare bank per possible length. Depends on cpm_pkg.
module cpm_rot_cmp #(
    parameter int MAX_PATTERN = cpm_pkg::DEFAULT_MAX_PATTERN
) (
    input  logic [MAX_PATTERN-1:0][cpm_pkg::CHAR_W-1:0]  window,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]             count,
    input  logic [cpm_pkg::PAT_BITS-1:0]                 pattern_chars,
    input  logic [cpm_pkg::LEN_W-1:0]                    pattern_length,
    output logic                                         hit
);
    import cpm_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    logic [LEN_W-1:0]     eff_len;
    logic [CNT_W-1:0]     eff_sel;
    logic [MAX_PATTERN:0] len_hit;

    // lengths above the window depth act as the full depth
    assign eff_len    = (pattern_length > LEN_MAX) ? LEN_MAX : pattern_length;
    assign eff_sel    = eff_len[CNT_W-1:0];
    assign len_hit[0] = 1'b0;

    for (genvar gn = 1; gn <= MAX_PATTERN; gn++) begin : g_len
        logic [gn-1:0] rot_ok;
        for (genvar gr = 0; gr < gn; gr++) begin : g_rot
            logic [gn-1:0] byte_eq;
            // window entry gn-1 is the oldest of the newest gn characters
            for (genvar gk = 0; gk < gn; gk++) begin : g_chr
                localparam int PAT_IDX = (gr + gk) % gn;
                assign byte_eq[gk] =
                    (window[gn-1-gk] == pattern_chars[CHAR_W*PAT_IDX +: CHAR_W]);
            end
            assign rot_ok[gr] = &byte_eq;
        end
        assign len_hit[gn] = |rot_ok;
    end

    assign hit = (eff_sel != '0) && (count >= eff_sel) && len_hit[eff_sel];

endmodule

// ===== test/tb_top.sv =====
// Testbench for circular_pattern_matcher: streams texts with embedded pattern
// rotations and checks found/found_last against a built-in predictor.
// Depends on cpm_pkg and the circular_pattern_matcher RTL.
`timescale 1ns / 1ps

module tb_top;
    import cpm_pkg::*;

    localparam int                   CYCLE_LIMIT = 200000;
    localparam int                   WIN_DEPTH   = 8;
    localparam int                   PHASE_ITEMS = 160;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    // Tracks the expected found flag per character and checks the results.
    class match_tracker;
        logic [CHAR_W-1:0]   recent [WIN_DEPTH];
        int unsigned         seen;
        bit                  sticky;
        logic [PAT_BITS-1:0] pat_bytes;
        logic [LEN_W-1:0]    pat_len;
        out_item_t           found_q[$];
        int unsigned         errors;
        int unsigned         n_results;

        function new();
            clear_text();
            pat_bytes = '0;
            pat_len   = '0;
            errors    = 0;
            n_results = 0;
        endfunction

        function void clear_text();
            foreach (recent[i]) recent[i] = '0;
            seen   = 0;
            sticky = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_BITS-1:0] data);
            if (idx == REG_PATTERN_CHARS)
                pat_bytes = data;
            else if (idx == REG_PATTERN_LENGTH)
                pat_len = data[LEN_W-1:0];
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        // one accepted character: shift it in and predict its result
        function void note_char(in_item_t it);
            out_item_t res;
            int        n;
            bit        ok;
            for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = it.text_char;
            if (seen < WIN_DEPTH) seen++;
            n = (pat_len > WIN_DEPTH) ? WIN_DEPTH : int'(pat_len);
            if (n > 0 && seen >= n) begin
                for (int r = 0; r < n; r++) begin
                    ok = 1;
                    for (int k = 0; k < n; k++) begin
                        if (recent[n-1-k] != pat_bytes[8*((r+k)%n) +: 8]) ok = 0;
                    end
                    if (ok) sticky = 1;
                end
            end
            res.found      = sticky;
            res.found_last = it.text_last;
            found_q.push_back(res);
            if (it.text_last) clear_text();
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            n_results++;
            if (found_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending", n_results));
                return;
            end
            want = found_q.pop_front();
            if (got.found !== want.found)
                report($sformatf("result %0d: found %b, want %b",
                                 n_results, got.found, want.found));
            if (got.found_last !== want.found_last)
                report($sformatf("result %0d: found_last %b, want %b",
                                 n_results, got.found_last, want.found_last));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PAT_BITS-1:0]  cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;

    match_tracker tracker = new();
    int unsigned  cycles;
    int unsigned  chars_sent;

    circular_pattern_matcher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result side: check every transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
    end

    // result side back-pressure: random stalls, one long hold-off, one clean stretch
    initial begin
        int unsigned rcyc;
        rcyc = 0;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            rcyc++;
            if (rcyc >= 700 && rcyc < 1000)
                m_ready <= 1'b0;
            else if (rcyc >= 1300 && rcyc < 2100)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 99) >= 7);
        end
    end

    // drive one character; the caller is always just past a rising edge
    task automatic send_char(in_item_t it);
        if ((chars_sent < 1000 || chars_sent >= 1300) && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        tracker.note_char(it);
        chars_sent++;
    endtask

    task automatic send_text(char_q_t chars);
        in_item_t it;
        for (int i = 0; i < chars.size(); i++) begin
            it.text_char = chars[i];
            it.text_last = (i == chars.size() - 1);
            send_char(it);
        end
    endtask

    // stop offering and let every pending result come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.found_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        tracker.set_reg(idx, data);
    endtask

    task automatic configure(logic [PAT_BITS-1:0] pat, logic [LEN_W-1:0] len, bit spare);
        logic [PAT_BITS-1:0] len_word;
        wait_idle();
        len_word            = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        write_reg(REG_PATTERN_CHARS, pat);
        write_reg(REG_PATTERN_LENGTH, len_word);
        // writes to unused indexes must leave the pattern alone
        if (spare) begin
            write_reg(REG_SPARE_A, {$urandom, $urandom});
            write_reg(REG_SPARE_B, {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [PAT_BITS-1:0] make_pattern();
        logic [PAT_BITS-1:0] p;
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 3) != 0)
                p[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 3));
            else
                p[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        return p;
    endfunction

    // random text, mostly built around a whole or damaged rotation
    function automatic char_q_t make_text(logic [PAT_BITS-1:0] pat, logic [LEN_W-1:0] len);
        char_q_t     t;
        int          n, tlen, pos, rot, mode, bad;
        logic [7:0]  c;
        n    = (len > WIN_DEPTH) ? WIN_DEPTH : int'(len);
        tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        for (int i = 0; i < tlen; i++) begin
            if ($urandom_range(0, 99) < 55)
                c = pat[8*$urandom_range(0, (n == 0) ? 7 : n - 1) +: 8];
            else
                c = 8'($urandom_range(0, 255));
            t.push_back(c);
        end
        mode = $urandom_range(0, 9);
        if (n > 0 && mode < 8) begin
            pos = $urandom_range(0, tlen);
            rot = $urandom_range(0, n - 1);
            bad = $urandom_range(0, n - 1);
            for (int k = 0; k < n; k++) begin
                c = pat[8*((rot + k) % n) +: 8];
                if (mode >= 6 && k == bad) c = c ^ (8'h01 << $urandom_range(0, 7));
                t.insert(pos + k, c);
            end
        end
        return t;
    endfunction

    initial begin
        int                  phase_len [12];
        logic [PAT_BITS-1:0] pat;
        int unsigned         start;
        phase_len  = '{3, 8, 8, 0, 1, 15, 9, 2, 5, 6, 7, 4};
        cycles     = 0;
        chars_sent = 0;
        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        s_valid    <= 1'b0;
        s_data     <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: pattern "abc"
        configure(64'h0000_0000_0063_6261, 4'd3, 1'b0);
        send_text('{8'h63, 8'h61, 8'h62});                    // rotation ends on last char
        send_text('{8'hFF, 8'h00, 8'h62, 8'h63, 8'h61, 8'h7A}); // sticky after match
        send_text('{8'h61});                                  // shorter than pattern
        send_text('{8'h62, 8'h61});
        send_text('{8'h61, 8'h62, 8'h63});                    // straight copy
        send_text('{8'h62, 8'h63, 8'h62, 8'h61});             // near miss

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 1)
                pat = '1;
            else if (ph == 2)
                pat = '0;
            else
                pat = make_pattern();
            configure(pat, LEN_W'(phase_len[ph]), ph == 3);
            start = chars_sent;
            while (chars_sent - start < PHASE_ITEMS) send_text(make_text(pat, LEN_W'(phase_len[ph])));
        end

        wait_idle();
        if (tracker.found_q.size() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.found_q.size()));
        if (tracker.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== circular_pattern_matcher.f =====
hdl/cpm_pkg.sv
hdl/cpm_window.sv
hdl/cpm_rot_cmp.sv
hdl/circular_pattern_matcher.sv
test/tb_top.sv
